/* hdl/muldiv_math_unit_registers_defines.svh */
// ----------------------------------------------------------------------------
// Math unit register block: assertion macros
// Shared concurrent-assertion wrappers; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULDIV_MATH_UNIT_REGISTERS_DEFINES_SVH
`define MULDIV_MATH_UNIT_REGISTERS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define MDMU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mdmu assertion failed");
// Next-cycle implication.
`define MDMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mdmu assertion failed");
`else
`define MDMU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define MDMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/mdmu_pkg.sv */
// ----------------------------------------------------------------------------
// Math unit register block: package
// Widths, register map, mode codes and the engine command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mdmu_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned OFFS_W = 6;
    localparam int unsigned OPND_W = 16;
    localparam int unsigned ACC_W  = 32;

    // bus access kind
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // write map (all six offset bits)
    localparam logic [5:0] WR_MODE = 6'h15;
    localparam logic [5:0] WR_A_LO = 6'h16;
    localparam logic [5:0] WR_A_HI = 6'h17;
    localparam logic [5:0] WR_B_LO = 6'h18;
    localparam logic [5:0] WR_B_HI = 6'h19;

    // read map (low five offset bits)
    localparam logic [4:0] RD_ID0   = 5'h00;
    localparam logic [4:0] RD_ID1   = 5'h01;
    localparam logic [4:0] RD_MAJOR = 5'h02;
    localparam logic [4:0] RD_MINOR = 5'h03;
    localparam logic [4:0] RD_ACC0  = 5'h1A;
    localparam logic [4:0] RD_ACC1  = 5'h1B;
    localparam logic [4:0] RD_ACC2  = 5'h1C;
    localparam logic [4:0] RD_ACC3  = 5'h1D;

    localparam logic [7:0] ID_BYTE0       = 8'h53;
    localparam logic [7:0] ID_BYTE1       = 8'h42;
    localparam logic [7:0] VER_MAJOR      = 8'h01;
    localparam logic [7:0] VER_MINOR_EXT  = 8'h02;
    localparam logic [7:0] VER_MINOR_BASE = 8'h01;
    localparam logic [7:0] READ_FILL      = 8'hFF;

    // mode byte codes
    localparam logic [7:0] MODE_MUL  = 8'h00;
    localparam logic [7:0] MODE_MAC  = 8'h01;
    localparam logic [7:0] MODE_SDIV = 8'h02;
    localparam logic [7:0] MODE_UDIV = 8'h04;

    localparam logic [31:0] SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] OPND_MIN = 16'h8000;
    localparam logic [15:0] OPND_M1  = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_MAC,
        OP_SDIV,
        OP_UDIV
    } mdmu_op_t;

    typedef struct packed {
        logic     start;
        mdmu_op_t op;
    } mdmu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdmu_stat_t;

endpackage

`default_nettype wire

/* hdl/mdmu_engine.sv */
// ----------------------------------------------------------------------------
// Math unit register block: serial arithmetic engine
// Bit-serial shift-add multiply and restoring 16.16 divide on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module mdmu_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mdmu_pkg::mdmu_cmd_t cmd,
    input  wire logic [15:0]         opnd_a,
    input  wire logic [15:0]         opnd_b,
    input  wire logic [31:0]         acc_in,
    output mdmu_pkg::mdmu_stat_t     stat,
    output logic [31:0]              result
);
    import mdmu_pkg::*;

    localparam logic [4:0] MUL_LAST = 5'(OPND_W - 1);
    localparam logic [4:0] DIV_LAST = 5'(ACC_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_ADD
    } state_t;

    state_t      state_reg;
    mdmu_op_t    op_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] mag_reg;     // |A| for multiply, divisor for divide
    logic [16:0] hi_reg;      // product high half / partial remainder
    logic [31:0] lo_reg;      // multiplier / dividend then quotient
    logic [31:0] result_reg;

    logic        a_neg;
    logic        b_neg;
    logic [15:0] a_mag;
    logic [15:0] b_mag;
    logic [16:0] mul_sum;
    logic [16:0] div_shift;
    logic [17:0] div_diff;
    logic        div_fit;
    logic [31:0] mag_res;
    logic [31:0] signed_res;

    always_comb
    begin
        a_neg      = opnd_a[15];
        b_neg      = opnd_b[15];
        a_mag      = a_neg ? (~opnd_a + 16'd1) : opnd_a;
        b_mag      = b_neg ? (~opnd_b + 16'd1) : opnd_b;
        mul_sum    = {1'b0, hi_reg[15:0]} + (lo_reg[0] ? {1'b0, mag_reg} : 17'd0);
        div_shift  = {hi_reg[15:0], lo_reg[31]};
        div_diff   = {1'b0, div_shift} - {2'b00, mag_reg};
        div_fit    = ~div_diff[17];
        mag_res    = (op_reg == OP_MUL || op_reg == OP_MAC)
                     ? {hi_reg[15:0], lo_reg[15:0]} : lo_reg;
        signed_res = neg_reg ? (~mag_res + 32'd1) : mag_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_MUL;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            mag_reg    <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.start)
                    begin
                        op_reg <= cmd.op;
                        hi_reg <= '0;
                        case (cmd.op)
                            OP_MUL, OP_MAC:
                            begin
                                mag_reg   <= a_mag;
                                lo_reg    <= {16'h0000, b_mag};
                                neg_reg   <= a_neg ^ b_neg;
                                cnt_reg   <= MUL_LAST;
                                state_reg <= ST_MUL;
                            end
                            OP_SDIV:
                            begin
                                if (opnd_b == 16'h0000)
                                begin
                                    result_reg <= a_neg ? SAT_NEG : SAT_POS;
                                    done_reg   <= 1'b1;
                                end
                                else if (opnd_a == OPND_MIN && opnd_b == OPND_M1)
                                begin
                                    result_reg <= SAT_POS;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    mag_reg   <= b_mag;
                                    lo_reg    <= {a_mag, 16'h0000};
                                    neg_reg   <= a_neg ^ b_neg;
                                    cnt_reg   <= DIV_LAST;
                                    state_reg <= ST_DIV;
                                end
                            end
                            OP_UDIV:
                            begin
                                if (opnd_b == 16'h0000)
                                begin
                                    result_reg <= ALL_ONES;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    mag_reg   <= opnd_b;
                                    lo_reg    <= {opnd_a, 16'h0000};
                                    neg_reg   <= 1'b0;
                                    cnt_reg   <= DIV_LAST;
                                    state_reg <= ST_DIV;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    hi_reg  <= {1'b0, mul_sum[16:1]};
                    lo_reg  <= {16'h0000, mul_sum[0], lo_reg[15:1]};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= ST_SIGN;
                end
                ST_DIV:
                begin
                    hi_reg  <= div_fit ? div_diff[16:0] : div_shift;
                    lo_reg  <= {lo_reg[30:0], div_fit};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= ST_SIGN;
                end
                ST_SIGN:
                begin
                    result_reg <= signed_res;
                    if (op_reg == OP_MAC)
                        state_reg <= ST_ADD;
                    else
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                ST_ADD:
                begin
                    // wraps modulo 2^32
                    result_reg <= result_reg + acc_in;
                    state_reg  <= ST_IDLE;
                    done_reg   <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

/* hdl/muldiv_math_unit_registers.sv */
// ----------------------------------------------------------------------------
// Math unit register block: top level
// Byte-wide register device with a serial 16-bit multiply / MAC / divide unit.
// ----------------------------------------------------------------------------
// Every accepted bus transaction returns exactly one read_data byte (zero for
// writes). A read or an ordinary write is registered into the output
// register, and the next transaction can be accepted in the cycle the result
// is taken. Writing offset 0x19 (operand B high byte) with a valid mode byte
// launches the serial engine, and in_ready stays low until the accumulator
// holds the new value: multiply takes 16 shift-add steps plus a sign step,
// multiply-add one more step for the accumulate, and the 16.16 divides 32
// restoring steps plus a sign step. Divide-by-zero and signed overflow
// saturate at launch without running the shift loop. The one-bit-per-cycle
// shift loop in mdmu_engine sets these step counts. Unknown modes leave the
// accumulator alone and do not stall. The readback enable (cfg_we / cfg_wdata)
// resets to 1; with it low the accumulator bytes read 0xFF and the minor
// version reads 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "muldiv_math_unit_registers_defines.svh"

module muldiv_math_unit_registers (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [5:0] reg_offset,
    input  wire logic [7:0] write_data,
    // response channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata
);
    import mdmu_pkg::*;

    // architectural state
    logic        rb_en_reg;
    logic [7:0]  op_mode_reg;
    logic [15:0] opnd_a_reg;
    logic [15:0] opnd_b_reg;
    logic [31:0] acc_reg;

    // engine launch, registered from the starting write
    mdmu_cmd_t   cmd_reg;
    mdmu_cmd_t   cmd_next;

    // output register
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;

    logic        in_fire;
    logic        is_write;
    logic        mode_ok;
    mdmu_op_t    mode_op;
    logic [7:0]  rd_byte;
    logic [7:0]  op_mode_next;
    logic [15:0] opnd_a_next;
    logic [15:0] opnd_b_next;

    mdmu_stat_t  eng_stat;
    logic [31:0] eng_result;

    // hold off new transactions until a launched operation has written back
    assign in_ready = ~(cmd_reg.start | eng_stat.busy | eng_stat.done)
                      & (~out_valid_reg | out_ready);
    assign in_fire  = in_valid & in_ready;
    assign is_write = (kind == KIND_WRITE);

    // mode byte to engine operation
    always_comb
    begin
        mode_ok = 1'b1;
        mode_op = OP_MUL;
        case (op_mode_reg)
            MODE_MUL:  mode_op = OP_MUL;
            MODE_MAC:  mode_op = OP_MAC;
            MODE_SDIV: mode_op = OP_SDIV;
            MODE_UDIV: mode_op = OP_UDIV;
            default:   mode_ok = 1'b0;
        endcase
    end

    // read decode: low five offset bits only
    always_comb
    begin
        case (reg_offset[4:0])
            RD_ID0:   rd_byte = ID_BYTE0;
            RD_ID1:   rd_byte = ID_BYTE1;
            RD_MAJOR: rd_byte = VER_MAJOR;
            RD_MINOR: rd_byte = rb_en_reg ? VER_MINOR_EXT : VER_MINOR_BASE;
            RD_ACC0:  rd_byte = rb_en_reg ? acc_reg[7:0]   : READ_FILL;
            RD_ACC1:  rd_byte = rb_en_reg ? acc_reg[15:8]  : READ_FILL;
            RD_ACC2:  rd_byte = rb_en_reg ? acc_reg[23:16] : READ_FILL;
            RD_ACC3:  rd_byte = rb_en_reg ? acc_reg[31:24] : READ_FILL;
            default:  rd_byte = READ_FILL;
        endcase
    end

    // write decode: all six offset bits
    always_comb
    begin
        op_mode_next   = op_mode_reg;
        opnd_a_next    = opnd_a_reg;
        opnd_b_next    = opnd_b_reg;
        cmd_next.start = 1'b0;
        cmd_next.op    = mode_op;
        if (in_fire && is_write)
        begin
            case (reg_offset)
                WR_MODE: op_mode_next = write_data;
                WR_A_LO: opnd_a_next  = {opnd_a_reg[15:8], write_data};
                WR_A_HI: opnd_a_next  = {write_data, opnd_a_reg[7:0]};
                WR_B_LO: opnd_b_next  = {opnd_b_reg[15:8], write_data};
                WR_B_HI:
                begin
                    opnd_b_next    = {write_data, opnd_b_reg[7:0]};
                    cmd_next.start = mode_ok;
                end
                default: op_mode_next = op_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_en_reg     <= 1'b1;
            op_mode_reg   <= 8'h00;
            opnd_a_reg    <= 16'hFFFF;
            opnd_b_reg    <= 16'hFFFF;
            acc_reg       <= ALL_ONES;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= 8'h00;
        end
        else
        begin
            if (cfg_we)
                rb_en_reg <= cfg_wdata;
            op_mode_reg <= op_mode_next;
            opnd_a_reg  <= opnd_a_next;
            opnd_b_reg  <= opnd_b_next;
            cmd_reg     <= cmd_next;
            if (eng_stat.done)
                acc_reg <= eng_result;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                read_data_reg <= is_write ? 8'h00 : rd_byte;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    mdmu_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_reg),
        .opnd_a (opnd_a_reg),
        .opnd_b (opnd_b_reg),
        .acc_in (acc_reg),
        .stat   (eng_stat),
        .result (eng_result)
    );

    // accumulator moves only on an engine write-back
    `MDMU_ASSERT_NEXT(a_acc_hold, clk, rst_n, !eng_stat.done, $stable(acc_reg))
    // write-back only ends a launched or running operation
    `MDMU_ASSERT_IMPLIES(a_done_src, clk, rst_n, eng_stat.done, $past(cmd_reg.start || eng_stat.busy))
    // a launch never lands on a busy engine
    `MDMU_ASSERT_IMPLIES(a_start_idle, clk, rst_n, cmd_reg.start, !eng_stat.busy && !eng_stat.done)
    // a response only follows an accepted transaction
    `MDMU_ASSERT_IMPLIES(a_resp_src, clk, rst_n, $rose(out_valid_reg), $past(in_valid && in_ready))

endmodule

`default_nettype wire
